// ===== hdl/lfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line follower PID drive unit
// Widths, register map, reset values and sequencer states.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int SUM_WIDTH = 16;
  localparam int CTRL_W    = SUM_WIDTH + 10;
  localparam int MUL_W     = CTRL_W + 9;
  localparam int LVL_W     = MUL_W + 1;
  localparam int ADDR_W    = 5;

  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_BASE_SPEED  = 3'd3;
  localparam logic [2:0] REG_STEER_GAIN  = 3'd4;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd5;

  localparam logic [7:0] RST_PROP_GAIN   = 8'd14;
  localparam logic [7:0] RST_INTEG_GAIN  = 8'd0;
  localparam logic [7:0] RST_DERIV_GAIN  = 8'd14;
  localparam logic [7:0] RST_BASE_SPEED  = 8'd80;
  localparam logic [7:0] RST_STEER_GAIN  = 8'd20;
  localparam logic [7:0] RST_SPEED_LIMIT = 8'd255;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MULP = 6'b000010,
    S_MULI = 6'b000100,
    S_MULD = 6'b001000,
    S_MULS = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage

// ===== hdl/line_follower_pid_drive_unit.sv =====
// ----------------------------------------------------------------------------
// line_follower_pid_drive_unit
// Decodes five line sensors, runs a PID loop and drives two motors.
// ----------------------------------------------------------------------------
// Each request passes through the sequencer from acceptance to a loaded result. The
// sensor decode and the error sum update happen at the accepting edge. Then
// come four passes through the single shared multiplier (proportional,
// integral, derivative, steer) and the S_DONE state, which forms and clamps both
// motor levels. The input side is not ready during that time, so a new request
// is accepted only once the sequencer is back in S_IDLE. A finished request
// holds while the result register is full and not being taken. The result
// register lets the next request start while a result waits.
module line_follower_pid_drive_unit
  import lfpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [4:0] sensor_bits
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,   // [3:0] line_position, [11:4] left_drive,
                                            // [12] left_backward, [20:13] right_drive,
                                            // [21] right_backward
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  function automatic logic [8:0] drive_f(input logic signed [LVL_W-1:0] num,
                                         input logic [7:0] lim);
    logic signed [LVL_W-1:0] adj;
    logic signed [LVL_W-1:0] quo;
    logic        [LVL_W-1:0] mag;
    logic        [7:0]       mag8;
    adj = num + {{(LVL_W-4){1'b0}}, {4{num[LVL_W-1]}}};
    quo = adj >>> 4;
    mag = quo[LVL_W-1] ? LVL_W'(-quo) : LVL_W'(quo);
    if (mag > {{(LVL_W-8){1'b0}}, lim}) begin
      mag8 = lim;
    end else begin
      mag8 = mag[7:0];
    end
    return {quo[LVL_W-1], mag8};
  endfunction

  state_e state_q, state_d;

  logic [7:0] prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [7:0] base_speed_q, steer_gain_q, speed_limit_q;

  logic signed [3:0]           last_pos_q;
  logic signed [3:0]           prev_err_q;
  logic signed [SUM_WIDTH-1:0] sum_q;
  logic signed [4:0]           diff_q;
  logic signed [CTRL_W-1:0]    acc_q;
  logic signed [MUL_W-1:0]     steer_q;
  logic                        out_valid_q;
  logic [23:0]                 out_data_q;

  logic                        in_acc, cfg_wr, out_load;
  logic signed [3:0]           pos, err;
  logic signed [SUM_WIDTH:0]   sum_ext;
  logic signed [SUM_WIDTH-1:0] sum_new;
  logic [7:0]                  mul_g;
  logic signed [MUL_W-1:0]     mul_a, mul_b, mul_p;
  logic signed [LVL_W-1:0]     left_num, right_num;
  logic [8:0]                  left_drv, right_drv;

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    case (paddr[4:2])
      REG_PROP_GAIN:   prdata = {24'd0, prop_gain_q};
      REG_INTEG_GAIN:  prdata = {24'd0, integ_gain_q};
      REG_DERIV_GAIN:  prdata = {24'd0, deriv_gain_q};
      REG_BASE_SPEED:  prdata = {24'd0, base_speed_q};
      REG_STEER_GAIN:  prdata = {24'd0, steer_gain_q};
      REG_SPEED_LIMIT: prdata = {24'd0, speed_limit_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    case (s_axis_tdata[4:0])
      5'b10000: pos = -4'sd4;
      5'b11000: pos = -4'sd3;
      5'b01000: pos = -4'sd2;
      5'b01100: pos = -4'sd1;
      5'b00100: pos = 4'sd0;
      5'b00110: pos = 4'sd1;
      5'b00010: pos = 4'sd2;
      5'b00011: pos = 4'sd3;
      5'b00001: pos = 4'sd4;
      5'b00000: pos = last_pos_q[3] ? -4'sd5 : 4'sd5;
      default:  pos = 4'sd5;
    endcase
    err     = -pos;
    sum_ext = {sum_q[SUM_WIDTH-1], sum_q} + {{(SUM_WIDTH-3){err[3]}}, err};
    if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
      sum_new = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                   : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_new = sum_ext[SUM_WIDTH-1:0];
    end
  end

  // shared multiplier: unsigned gain times signed operand
  always_comb begin
    case (state_q)
      S_MULP: begin
        mul_g = prop_gain_q;
        mul_b = {{(MUL_W-4){prev_err_q[3]}}, prev_err_q};
      end
      S_MULI: begin
        mul_g = integ_gain_q;
        mul_b = {{(MUL_W-SUM_WIDTH){sum_q[SUM_WIDTH-1]}}, sum_q};
      end
      S_MULD: begin
        mul_g = deriv_gain_q;
        mul_b = {{(MUL_W-5){diff_q[4]}}, diff_q};
      end
      S_MULS: begin
        mul_g = steer_gain_q;
        mul_b = {{(MUL_W-CTRL_W){acc_q[CTRL_W-1]}}, acc_q};
      end
      default: begin
        mul_g = 8'd0;
        mul_b = '0;
      end
    endcase
    mul_a = {{(MUL_W-8){1'b0}}, mul_g};
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    left_num  = {{(LVL_W-12){1'b0}}, base_speed_q, 4'd0} + {steer_q[MUL_W-1], steer_q};
    right_num = {{(LVL_W-12){1'b0}}, base_speed_q, 4'd0} - {steer_q[MUL_W-1], steer_q};
    left_drv  = drive_f(left_num, speed_limit_q);
    right_drv = drive_f(right_num, speed_limit_q);
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_MULP;
      S_MULP:  state_d = S_MULI;
      S_MULI:  state_d = S_MULD;
      S_MULD:  state_d = S_MULS;
      S_MULS:  state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      last_pos_q    <= '0;
      prev_err_q    <= '0;
      sum_q         <= '0;
      prop_gain_q   <= RST_PROP_GAIN;
      integ_gain_q  <= RST_INTEG_GAIN;
      deriv_gain_q  <= RST_DERIV_GAIN;
      base_speed_q  <= RST_BASE_SPEED;
      steer_gain_q  <= RST_STEER_GAIN;
      speed_limit_q <= RST_SPEED_LIMIT;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_PROP_GAIN:   prop_gain_q   <= pwdata[7:0];
          REG_INTEG_GAIN:  integ_gain_q  <= pwdata[7:0];
          REG_DERIV_GAIN:  deriv_gain_q  <= pwdata[7:0];
          REG_BASE_SPEED:  base_speed_q  <= pwdata[7:0];
          REG_STEER_GAIN:  steer_gain_q  <= pwdata[7:0];
          REG_SPEED_LIMIT: speed_limit_q <= pwdata[7:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_pos_q <= pos;
        prev_err_q <= err;
        sum_q      <= sum_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      diff_q <= {err[3], err} - {prev_err_q[3], prev_err_q};
    end
    case (state_q)
      S_MULP:  acc_q <= mul_p[CTRL_W-1:0];
      S_MULI:  acc_q <= acc_q + mul_p[CTRL_W-1:0];
      S_MULD:  acc_q <= acc_q + mul_p[CTRL_W-1:0];
      S_MULS:  steer_q <= mul_p;
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= {2'b00, right_drv[8], right_drv[7:0], left_drv[8], left_drv[7:0],
                     last_pos_q};
    end
  end

endmodule
